// File: hdl/dpfa_pkg.sv
// Shared types and constants for the demand page frame allocator.
// Holds field widths, op and status codes, and the controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps

package dpfa_pkg;

    // Field widths of the input and result words
    localparam int OP_W     = 2;
    localparam int PROC_W   = 4;
    localparam int PAGE_W   = 11;
    localparam int STAT_W   = 3;
    localparam int FRAME_OW = 14;
    localparam int TOTAL_W  = 32;

    typedef logic [OP_W-1:0]   t_op;
    typedef logic [STAT_W-1:0] t_status;

    // Operation codes
    localparam t_op OP_ACCESS  = 2'd0;
    localparam t_op OP_ALLOC   = 2'd1;
    localparam t_op OP_RELEASE = 2'd2;

    // Result status codes
    localparam t_status ST_HIT      = 3'd0;
    localparam t_status ST_FAULT    = 3'd1;
    localparam t_status ST_SWAPPED  = 3'd2;
    localparam t_status ST_NOFRAME  = 3'd3;
    localparam t_status ST_RELEASED = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic decide;
        logic walk_rd;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic in_acc;
        logic in_rel;
        logic need_swap;
        logic walk_last;
        logic out_free;
    } t_sts;

endpackage

// File: hdl/dpfa_ctrl.sv
// Controller state machine of the demand page frame allocator.
// Sequences the reset clear, lookup, page walk and result handoff.
// Depends on dpfa_pkg.
`timescale 1ns / 1ps

module dpfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  dpfa_pkg::t_sts i_sts,
    output dpfa_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import dpfa_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    priority if (i_sts.in_acc) begin
                        n_state = S_DECIDE;
                    end else if (i_sts.in_rel) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.need_swap ? S_WALK : S_RESP;
            end
            S_WALK: begin
                o_cmd.walk_rd = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/dpfa_datapath.sv
// Datapath of the demand page frame allocator: page table memory,
// free frame FIFO memory, counters and the result register.
// Depends on dpfa_pkg; driven by dpfa_ctrl commands.
`timescale 1ns / 1ps

module dpfa_datapath #(
    parameter int PROCESSES         = 16,
    parameter int PAGES_PER_PROCESS = 2048,
    parameter int FRAMES            = 12288
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dpfa_pkg::t_cmd                    i_cmd,
    output dpfa_pkg::t_sts                    o_sts,
    input  logic [dpfa_pkg::OP_W-1:0]         i_op,
    input  logic [dpfa_pkg::PROC_W-1:0]       i_process_id,
    input  logic [dpfa_pkg::PAGE_W-1:0]       i_page,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [dpfa_pkg::STAT_W-1:0]       o_status,
    output logic [dpfa_pkg::FRAME_OW-1:0]     o_frame,
    output logic [dpfa_pkg::TOTAL_W-1:0]      o_access_total,
    output logic [dpfa_pkg::TOTAL_W-1:0]      o_fault_total,
    output logic [dpfa_pkg::TOTAL_W-1:0]      o_swap_total
);
    import dpfa_pkg::*;

    // Reachable processes and pages are limited by the field widths
    localparam int NPROC  = (PROCESSES < 2**PROC_W) ? PROCESSES : 2**PROC_W;
    localparam int NPAGE  = (PAGES_PER_PROCESS < 2**PAGE_W) ?
                            PAGES_PER_PROCESS : 2**PAGE_W;
    localparam int PT_N   = NPROC * NPAGE;
    localparam int AW     = $clog2(PT_N);
    localparam int FW     = $clog2(FRAMES);
    localparam int CNTW   = $clog2(FRAMES + 1);
    localparam int WW     = $clog2(NPAGE);
    localparam int CLR_N  = (PT_N > FRAMES) ? PT_N : FRAMES;
    localparam int CW     = $clog2(CLR_N);
    localparam int IXW    = AW + PROC_W + 1;

    // Page table entry: valid bit over frame number
    logic [FW:0]      r_pt_mem [PT_N];
    logic [FW:0]      r_pt_q;
    logic [FW-1:0]    r_ff_mem [FRAMES];
    logic [FW-1:0]    r_ff_q;

    logic [FW-1:0]    r_head;
    logic [FW-1:0]    r_tail;
    logic [CNTW-1:0]  r_count;
    logic [TOTAL_W-1:0] r_acc_cnt;
    logic [TOTAL_W-1:0] r_flt_cnt;
    logic [TOTAL_W-1:0] r_swp_cnt;
    logic [CW-1:0]    r_clr;

    t_op              r_op;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_base;
    logic [WW-1:0]    r_walk;
    logic             r_wb_vld;
    logic [AW-1:0]    r_wb_addr;
    t_status          r_status;
    logic [FW-1:0]    r_frame;
    logic             r_out_vld;

    logic [IXW-1:0]   w_base_full;
    logic [IXW-1:0]   w_idx_full;
    logic [AW-1:0]    w_walk_addr;
    logic [AW-1:0]    w_pt_raddr;
    logic             w_pt_we;
    logic [AW-1:0]    w_pt_waddr;
    logic [FW:0]      w_pt_wdata;
    logic             w_ff_we;
    logic [FW-1:0]    w_ff_waddr;
    logic [FW-1:0]    w_ff_wdata;
    logic             w_counted;
    logic             w_hit;
    logic             w_empty;
    logic             w_pop;
    logic             w_push;
    logic             w_proc_ok;
    logic             w_page_ok;

    // Classify the offered word
    assign w_proc_ok = (32'(i_process_id) < NPROC);
    assign w_page_ok = (32'(i_page) < NPAGE);
    assign o_sts.in_acc = w_proc_ok && w_page_ok &&
                          (i_op == OP_ACCESS || i_op == OP_ALLOC);
    assign o_sts.in_rel = w_proc_ok && (i_op == OP_RELEASE);

    // Form table addresses
    assign w_base_full = IXW'(i_process_id) * IXW'(NPAGE);
    assign w_idx_full  = w_base_full + IXW'(i_page);
    assign w_walk_addr = r_base + AW'(r_walk);
    assign w_pt_raddr  = i_cmd.walk_rd ? w_walk_addr : w_idx_full[AW-1:0];

    // Decide terms
    assign w_counted = (r_op == OP_ACCESS);
    assign w_hit     = r_pt_q[FW];
    assign w_empty   = (r_count == '0);
    assign w_pop     = i_cmd.decide && !w_hit && !w_empty;
    assign w_push    = r_wb_vld && r_pt_q[FW] && (r_count < CNTW'(FRAMES));

    assign o_sts.need_swap = w_counted && !w_hit && w_empty;
    assign o_sts.walk_last = (r_walk == WW'(NPAGE - 1));
    assign o_sts.clr_last  = (r_clr == CW'(CLR_N - 1));
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    // Select the page table write
    always_comb begin
        w_pt_we    = 1'b0;
        w_pt_waddr = r_wb_addr;
        w_pt_wdata = '0;
        priority if (i_cmd.clear_step) begin
            w_pt_we    = ({1'b0, r_clr} < (CW+1)'(PT_N));
            w_pt_waddr = r_clr[AW-1:0];
        end else if (w_pop) begin
            w_pt_we    = 1'b1;
            w_pt_waddr = r_idx;
            w_pt_wdata = {1'b1, r_ff_q};
        end else if (r_wb_vld) begin
            w_pt_we    = 1'b1;
        end else begin
            w_pt_we    = 1'b0;
        end
    end

    // Select the free list write
    always_comb begin
        w_ff_we    = 1'b0;
        w_ff_waddr = r_tail;
        w_ff_wdata = r_pt_q[FW-1:0];
        priority if (i_cmd.clear_step) begin
            w_ff_we    = ({1'b0, r_clr} < (CW+1)'(FRAMES));
            w_ff_waddr = r_clr[FW-1:0];
            w_ff_wdata = r_clr[FW-1:0];
        end else begin
            w_ff_we    = w_push;
        end
    end

    // Page table memory
    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            r_pt_mem[w_pt_waddr] <= w_pt_wdata;
        end
        r_pt_q <= r_pt_mem[w_pt_raddr];
    end

    // Free frame memory, read at the head
    always_ff @(posedge i_clk) begin
        if (w_ff_we) begin
            r_ff_mem[w_ff_waddr] <= w_ff_wdata;
        end
        r_ff_q <= r_ff_mem[r_head];
    end

    // Advance FIFO pointers, counters and the clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= CNTW'(FRAMES);
            r_acc_cnt <= '0;
            r_flt_cnt <= '0;
            r_swp_cnt <= '0;
            r_clr     <= '0;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_pop) begin
                r_head  <= (r_head == FW'(FRAMES - 1)) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end else if (w_push) begin
                r_tail  <= (r_tail == FW'(FRAMES - 1)) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.decide && w_counted) begin
                r_acc_cnt <= r_acc_cnt + 1'b1;
                if (!w_hit) begin
                    r_flt_cnt <= r_flt_cnt + 1'b1;
                    if (w_empty) begin
                        r_swp_cnt <= r_swp_cnt + 1'b1;
                    end
                end
            end
            r_wb_vld <= i_cmd.walk_rd;
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Capture the word, walk the table and form the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_op;
            r_idx    <= w_idx_full[AW-1:0];
            r_base   <= w_base_full[AW-1:0];
            r_walk   <= '0;
            r_status <= o_sts.in_rel ? ST_RELEASED : ST_NOFRAME;
            r_frame  <= '0;
        end
        if (i_cmd.walk_rd) begin
            r_walk    <= r_walk + 1'b1;
            r_wb_addr <= w_walk_addr;
        end
        if (i_cmd.decide) begin
            priority if (w_hit) begin
                r_status <= ST_HIT;
                r_frame  <= r_pt_q[FW-1:0];
            end else if (!w_empty) begin
                r_status <= ST_FAULT;
                r_frame  <= r_ff_q;
            end else if (w_counted) begin
                r_status <= ST_SWAPPED;
            end else begin
                r_status <= ST_NOFRAME;
            end
        end
        if (i_cmd.load_out) begin
            o_status       <= r_status;
            o_frame        <= FRAME_OW'(r_frame);
            o_access_total <= r_acc_cnt;
            o_fault_total  <= r_flt_cnt;
            o_swap_total   <= r_swp_cnt;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// File: hdl/demand_page_frame_allocator_core.sv
// Top level of the demand page frame allocator.
// Joins the dpfa_ctrl state machine and the dpfa_datapath; uses dpfa_pkg.
//
//   channel | direction | handshake           | word
//   input   | in        | i_valid / o_ready   | i_op, i_process_id, i_page
//   result  | out       | o_valid / i_ready   | o_status, o_frame, o_*_total
//
// Access and allocate words reach the result register after one page-table read and then
// the decide step with its write-back; ignored words go to it directly.
// A release walks the process one entry per cycle through the single page-table
// read port; a swap-out walks the process too, after the decide step.
// After reset a clearing pass over the page table and the free frame list
// (ids and pages limited to 16 and 2048) runs with o_ready low.
// One word is worked at a time; the next is taken while a result waits.
`timescale 1ns / 1ps

module demand_page_frame_allocator_core #(
    parameter int PROCESSES         = 16,
    parameter int PAGES_PER_PROCESS = 2048,
    parameter int FRAMES            = 12288
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [dpfa_pkg::OP_W-1:0]         i_op,
    input  logic [dpfa_pkg::PROC_W-1:0]       i_process_id,
    input  logic [dpfa_pkg::PAGE_W-1:0]       i_page,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dpfa_pkg::STAT_W-1:0]       o_status,
    output logic [dpfa_pkg::FRAME_OW-1:0]     o_frame,
    output logic [dpfa_pkg::TOTAL_W-1:0]      o_access_total,
    output logic [dpfa_pkg::TOTAL_W-1:0]      o_fault_total,
    output logic [dpfa_pkg::TOTAL_W-1:0]      o_swap_total
);
    import dpfa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequence the work
    dpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_ready)
    );

    // Hold tables, counters and the result register
    dpfa_datapath #(
        .PROCESSES         (PROCESSES),
        .PAGES_PER_PROCESS (PAGES_PER_PROCESS),
        .FRAMES            (FRAMES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_op           (i_op),
        .i_process_id   (i_process_id),
        .i_page         (i_page),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_status       (o_status),
        .o_frame        (o_frame),
        .o_access_total (o_access_total),
        .o_fault_total  (o_fault_total),
        .o_swap_total   (o_swap_total)
    );

endmodule
